// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/cscan_pkg.sv =====
// Package with widths, register indexes and reset values of the C-SCAN scheduler.
`default_nettype none

package cscan_pkg;

  localparam int PosW     = 10;
  localparam int SumW     = 16;
  localparam int CfgAddrW = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegStartHead   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegDirectionUp = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTopCylinder = 2'd2;

  // Register reset values
  localparam logic [PosW-1:0] StartHeadReset   = 10'd0;
  localparam logic            DirectionUpReset = 1'b1;
  localparam logic [PosW-1:0] TopCylinderReset = 10'd199;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/core/cscan_disk_scheduler_unit.sv =====
// Top level of the C-SCAN disk scheduler: request store, ranking pass and move sequencer.
`default_nettype none
// Usage
//   Requests enter one item per cycle: an item is taken at a rising edge with
//   start high and busy low. Items without last_request are only stored; once
//   MAX_REQUESTS are stored, further requests are dropped.
//   The item with last_request set stores its request (if there is room) and
//   starts serving the batch of n stored requests.
//   Serving first ranks the batch: each request is read as a pivot and then
//   compared against every stored request through the store's read port, and
//   ranking writes the sorted copy into a second memory. Moves then follow:
//   each request is read from the sorted memory and then emitted, with the
//   end-of-sweep move and the return jump between the two sweeps.
//   Each result (position, total_movement, last_move) is shown for exactly one
//   cycle with strobe high; the receiver cannot stall. busy stays high from
//   the last item until the final move, whose strobe cycle already sees busy
//   low. Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at
//   once and are meant for idle periods only.
//   Synchronous reset empties the batch and restores register defaults; the
//   memories are not cleared, and only entries written in a batch are read.
module cscan_disk_scheduler_unit
  import cscan_pkg::*;
#(
  parameter int MAX_REQUESTS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [PosW-1:0]     request_cylinder,
  input  wire logic                last_request,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [PosW-1:0]     cfg_wdata,
  output      logic                strobe,
  output      logic [PosW-1:0]     position,
  output      logic [SumW-1:0]     total_movement,
  output      logic                last_move
);

  localparam int IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CntW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CntW-1:0] MaxCount = CntW'(MAX_REQUESTS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RPIV,
    ST_RPIVW,
    ST_RSCAN,
    ST_RWR,
    ST_ARD,
    ST_AEM,
    ST_EDGE,
    ST_JUMP,
    ST_DRD,
    ST_DEM
  } state_t;

  state_t state;

  // Configuration registers
  logic [PosW-1:0] start_head;
  logic            direction_up;
  logic [PosW-1:0] top_cylinder;

  // Control state
  logic [CntW-1:0] count;
  logic [CntW-1:0] n;
  logic [CntW-1:0] split;
  logic [CntW-1:0] j_idx;
  logic [IdxW-1:0] i_idx;
  logic [IdxW-1:0] k_idx;
  logic [IdxW-1:0] rank;
  logic [IdxW-1:0] cmp_idx;
  logic            cmp_v;
  logic [PosW-1:0] pivot;
  logic [PosW-1:0] head;
  logic [SumW-1:0] sum;

  // Memories
  logic [PosW-1:0] store_mem  [MAX_REQUESTS];
  logic [PosW-1:0] sorted_mem [MAX_REQUESTS];
  logic [PosW-1:0] st_rd;
  logic [PosW-1:0] so_rd;

  logic            accept;
  logic            st_rd_en;
  logic [IdxW-1:0] st_rd_addr;
  logic            so_rd_en;
  logic [IdxW-1:0] so_rd_addr;

  logic            emit_en;
  logic [PosW-1:0] emit_tgt;
  logic            emit_jump;
  logic            emit_last;
  logic [PosW-1:0] move_dist;
  logic [SumW:0]   sum_wide;
  logic [SumW-1:0] sum_next;

  logic [CntW-1:0] n_m1;
  logic [CntW-1:0] split_m1;
  logic [CntW-1:0] k_wide;
  logic            a_empty;
  logic            d_empty;
  logic            a_end;
  logic            d_end;
  logic            hit;
  logic [CntW-1:0] count_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign n_m1     = n - 1'b1;
  assign split_m1 = split - 1'b1;
  assign k_wide   = CntW'(k_idx);
  assign a_empty  = direction_up ? (split == n) : (split == '0);
  assign d_empty  = direction_up ? (split == '0) : (split == n);
  assign a_end    = direction_up ? (k_wide == n_m1) : (k_idx == '0);
  assign d_end    = direction_up ? (k_wide == split_m1) : (k_wide == n_m1);

  // Rank test: stored value sorts before the pivot, ties broken by position
  assign hit = (st_rd < pivot) || ((st_rd == pivot) && (cmp_idx < i_idx));

  assign count_next = (count < MaxCount) ? count + 1'b1 : count;

  // Select memory reads and the move to emit
  always_comb begin
    st_rd_en   = 1'b0;
    st_rd_addr = i_idx;
    so_rd_en   = 1'b0;
    so_rd_addr = k_idx;
    emit_en    = 1'b0;
    emit_tgt   = so_rd;
    emit_jump  = 1'b0;
    emit_last  = 1'b0;
    unique case (state)
      ST_RPIV: begin
        st_rd_en   = 1'b1;
        st_rd_addr = i_idx;
      end
      ST_RSCAN: begin
        st_rd_en   = (j_idx < n);
        st_rd_addr = j_idx[IdxW-1:0];
      end
      ST_ARD, ST_DRD: begin
        so_rd_en = 1'b1;
      end
      ST_AEM: begin
        emit_en = 1'b1;
      end
      ST_EDGE: begin
        emit_en  = 1'b1;
        emit_tgt = direction_up ? top_cylinder : '0;
      end
      ST_JUMP: begin
        emit_en   = 1'b1;
        emit_tgt  = direction_up ? '0 : top_cylinder;
        emit_jump = 1'b1;
        emit_last = d_empty;
      end
      ST_DEM: begin
        emit_en   = 1'b1;
        emit_last = d_end;
      end
      default: begin
      end
    endcase
  end

  // Move distance and saturating running total
  always_comb begin
    if (emit_jump) begin
      move_dist = top_cylinder;
    end else if (emit_tgt >= head) begin
      move_dist = emit_tgt - head;
    end else begin
      move_dist = head - emit_tgt;
    end
    sum_wide = {1'b0, sum} + (SumW + 1)'(move_dist);
    sum_next = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
  end

  // Request store: written on load, read during ranking
  always_ff @(posedge clk) begin
    if (accept && (count < MaxCount)) begin
      store_mem[count[IdxW-1:0]] <= request_cylinder;
    end
    if (st_rd_en) begin
      st_rd <= store_mem[st_rd_addr];
    end
  end

  // Sorted copy: written by rank, read during serving
  always_ff @(posedge clk) begin
    if (state == ST_RWR) begin
      sorted_mem[rank] <= pivot;
    end
    if (so_rd_en) begin
      so_rd <= sorted_mem[so_rd_addr];
    end
  end

  // Sequencer, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      start_head     <= StartHeadReset;
      direction_up   <= DirectionUpReset;
      top_cylinder   <= TopCylinderReset;
      count          <= '0;
      n              <= '0;
      split          <= '0;
      j_idx          <= '0;
      i_idx          <= '0;
      k_idx          <= '0;
      rank           <= '0;
      cmp_v          <= 1'b0;
      head           <= '0;
      sum            <= '0;
      strobe         <= 1'b0;
      last_move      <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_we) begin
        unique case (cfg_addr)
          RegStartHead:   start_head   <= cfg_wdata;
          RegDirectionUp: direction_up <= cfg_wdata[0];
          RegTopCylinder: top_cylinder <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // Drive one result per move
      strobe <= emit_en;
      if (emit_en) begin
        head           <= emit_tgt;
        sum            <= sum_next;
        position       <= emit_tgt;
        total_movement <= sum_next;
        last_move      <= emit_last;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (last_request) begin
              n     <= count_next;
              split <= '0;
              i_idx <= '0;
              state <= ST_RPIV;
            end
          end
        end
        ST_RPIV: begin
          state <= ST_RPIVW;
        end
        ST_RPIVW: begin
          // Latch pivot and count requests below the start head
          pivot <= st_rd;
          if (st_rd < start_head) begin
            split <= split + 1'b1;
          end
          j_idx <= '0;
          rank  <= '0;
          cmp_v <= 1'b0;
          state <= ST_RSCAN;
        end
        ST_RSCAN: begin
          if (cmp_v && hit) begin
            rank <= rank + 1'b1;
          end
          if (j_idx < n) begin
            cmp_v   <= 1'b1;
            cmp_idx <= j_idx[IdxW-1:0];
            j_idx   <= j_idx + 1'b1;
          end else begin
            cmp_v <= 1'b0;
            if (cmp_v) begin
              state <= ST_RWR;
            end
          end
        end
        ST_RWR: begin
          if (CntW'(i_idx) == n_m1) begin
            // Ranking done: start the schedule from the start head
            head <= start_head;
            sum  <= '0;
            if (direction_up) begin
              k_idx <= split[IdxW-1:0];
            end else begin
              k_idx <= split_m1[IdxW-1:0];
            end
            state <= a_empty ? ST_EDGE : ST_ARD;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= ST_RPIV;
          end
        end
        ST_ARD: begin
          state <= ST_AEM;
        end
        ST_AEM: begin
          if (a_end) begin
            state <= ST_EDGE;
          end else begin
            k_idx <= direction_up ? k_idx + 1'b1 : k_idx - 1'b1;
            state <= ST_ARD;
          end
        end
        ST_EDGE: begin
          state <= ST_JUMP;
        end
        ST_JUMP: begin
          if (d_empty) begin
            count <= '0;
            state <= ST_IDLE;
          end else begin
            k_idx <= direction_up ? '0 : split[IdxW-1:0];
            state <= ST_DRD;
          end
        end
        ST_DRD: begin
          state <= ST_DEM;
        end
        ST_DEM: begin
          if (d_end) begin
            count <= '0;
            state <= ST_IDLE;
          end else begin
            k_idx <= k_idx + 1'b1;
            state <= ST_DRD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_last_has_strobe, last_move && strobe |-> busy == 1'b0, "final move left busy high")
  `ASSERT_CLK(a_strobe_from_serve, strobe |-> $past(busy), "result without a batch in service")
  `ASSERT_CLK(a_rank_in_range, state == ST_RWR |-> CntW'(rank) < n, "rank beyond batch size")
  `ASSERT_NEVER(a_batch_overflow, count > MaxCount, "request count beyond store depth")

endmodule

`default_nettype wire
